@@ rtl/assert_macros.svh @@
// Assertion macros included by the histogram core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/phc_pkg.sv @@
// Constants and codes for the printable character histogram core.
package phc_pkg;

    localparam int CHAR_CLASSES = 95;
    localparam int COUNT_WIDTH  = 32;
    localparam int IDX_W        = $clog2(CHAR_CLASSES);
    localparam int VALUE_W      = 32;

    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

    localparam logic [2:0] FUNC_DATA   = 3'd0;
    localparam logic [2:0] FUNC_EOS    = 3'd1;
    localparam logic [2:0] FUNC_COMMIT = 3'd2;
    localparam logic [2:0] FUNC_ABORT  = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

endpackage

@@ rtl/printable_char_histogram_core.sv @@
// Printable character histogram: session and total bins with commit, abort and read.
//
//  channel  | direction | ports
//  ---------+-----------+------------------------------------------------
//  input    | in        | s_valid, s_ready, s_func, s_data_byte
//  result   | out       | m_valid, m_ready, m_value, m_kind, m_code_valid
//
// Printable data byte: read-modify-write of the session bin memory.
// Non-printable data byte, abort and unused codes: handled without leaving the idle state.
// End of stream and read: a result state that holds while the result register is full.
// Commit: a read state and a write state per bin, for all 95 bins, through the shared adder.
// Reset clears both tables at once through valid bits.
// A full result register stalls only end of stream and read, and holds the input meanwhile.
`include "assert_macros.svh"

module printable_char_histogram_core
    import phc_pkg::*;
#(
    parameter int CountW = COUNT_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_func,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [VALUE_W-1:0]  m_value,
    output logic                m_kind,
    output logic                m_code_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INC,
        S_EOS,
        S_RDTOT,
        S_CRD,
        S_CWR
    } state_t;

    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(CHAR_CLASSES - 1);

    state_t                   state_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     ok_reg;
    logic [CHAR_CLASSES-1:0]  sess_vld_reg;
    logic [CHAR_CLASSES-1:0]  tot_vld_reg;
    logic [CountW-1:0]        sess_cnt_reg;
    logic                     m_valid_reg;
    logic [VALUE_W-1:0]       m_value_reg;
    logic                     m_kind_reg;
    logic                     m_code_valid_reg;

    logic [CountW-1:0]        sess_mem [CHAR_CLASSES];
    logic [CountW-1:0]        tot_mem  [CHAR_CLASSES];
    logic [CountW-1:0]        sess_rdata_reg;
    logic [CountW-1:0]        tot_rdata_reg;

    logic [7:0]               in_diff;
    logic                     in_ok;
    logic [IDX_W-1:0]         in_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic [CountW-1:0]        sess_old;
    logic [CountW-1:0]        tot_old;
    logic [CountW-1:0]        sum;
    logic                     sess_we;
    logic                     tot_we;
    logic                     out_free;
    logic                     res_load;
    logic                     s_acc;
    logic [CountW+VALUE_W-1:0] cnt_ext;
    logic [CountW+VALUE_W-1:0] tot_ext;

    assign in_diff  = s_data_byte - FIRST_PRINTABLE;
    assign in_ok    = (s_data_byte >= FIRST_PRINTABLE) && (s_data_byte <= LAST_PRINTABLE);
    assign in_idx   = in_ok ? in_diff[IDX_W-1:0] : '0;
    assign rd_addr  = (state_reg == S_IDLE) ? in_idx : idx_reg;

    assign sess_old = sess_vld_reg[idx_reg] ? sess_rdata_reg : '0;
    assign tot_old  = tot_vld_reg[idx_reg] ? tot_rdata_reg : '0;

    // shared adder: bin increment or total accumulate
    assign sum      = (state_reg == S_CWR) ? (tot_old + sess_old)
                                           : (sess_old + CountW'(1));
    assign sess_we  = (state_reg == S_INC);
    assign tot_we   = (state_reg == S_CWR);

    assign out_free = !m_valid_reg || m_ready;
    assign res_load = ((state_reg == S_EOS) || (state_reg == S_RDTOT)) && out_free;
    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;

    assign cnt_ext  = {{VALUE_W{1'b0}}, sess_cnt_reg};
    assign tot_ext  = {{VALUE_W{1'b0}}, tot_old};

    always_ff @(posedge aclk) begin
        if (sess_we) begin
            sess_mem[idx_reg] <= sum;
        end
        if (tot_we) begin
            tot_mem[idx_reg] <= sum;
        end
        sess_rdata_reg <= sess_mem[rd_addr];
        tot_rdata_reg  <= tot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            ok_reg           <= 1'b0;
            sess_vld_reg     <= '0;
            tot_vld_reg      <= '0;
            sess_cnt_reg     <= '0;
            m_valid_reg      <= 1'b0;
            m_value_reg      <= '0;
            m_kind_reg       <= 1'b0;
            m_code_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        idx_reg <= (s_func == FUNC_COMMIT) ? '0 : in_idx;
                        ok_reg  <= in_ok;
                        unique case (s_func)
                            FUNC_DATA: begin
                                if (in_ok) begin
                                    sess_cnt_reg <= sess_cnt_reg + CountW'(1);
                                    state_reg    <= S_INC;
                                end
                            end
                            FUNC_EOS:    state_reg <= S_EOS;
                            FUNC_COMMIT: state_reg <= S_CRD;
                            FUNC_ABORT: begin
                                sess_vld_reg <= '0;
                                sess_cnt_reg <= '0;
                            end
                            FUNC_READ:   state_reg <= S_RDTOT;
                            default: ;
                        endcase
                    end
                end
                S_INC: begin
                    sess_vld_reg[idx_reg] <= 1'b1;
                    state_reg             <= S_IDLE;
                end
                S_EOS: begin
                    if (out_free) begin
                        m_value_reg      <= cnt_ext[VALUE_W-1:0];
                        m_kind_reg       <= 1'b0;
                        m_code_valid_reg <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
                S_RDTOT: begin
                    if (out_free) begin
                        m_value_reg      <= ok_reg ? tot_ext[VALUE_W-1:0] : '0;
                        m_kind_reg       <= 1'b1;
                        m_code_valid_reg <= ok_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                S_CRD: begin
                    state_reg <= S_CWR;
                end
                S_CWR: begin
                    tot_vld_reg[idx_reg] <= 1'b1;
                    if (idx_reg == LastIdx) begin
                        sess_vld_reg <= '0;
                        sess_cnt_reg <= '0;
                        state_reg    <= S_IDLE;
                    end else begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_CRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_kind       = m_kind_reg;
    assign m_code_valid = m_code_valid_reg;

    `ASSERT_NEXT(a_commit_step, aclk, aresetn, (state_reg == S_CWR) && (idx_reg != LastIdx), (state_reg == S_CRD) && (idx_reg == $past(idx_reg) + 1'b1))
    `ASSERT_NEXT(a_data_count, aclk, aresetn, s_acc && (s_func == FUNC_DATA) && in_ok, (state_reg == S_INC) && (sess_cnt_reg == $past(sess_cnt_reg) + 1'b1))
    `ASSERT_NEXT(a_abort_clear, aclk, aresetn, s_acc && (s_func == FUNC_ABORT), (sess_vld_reg == '0) && (sess_cnt_reg == '0))
    `ASSERT_SAME(a_busy_not_ready, aclk, aresetn, (state_reg == S_CRD) || (state_reg == S_CWR), !s_ready)

endmodule

@@ tb/phc_checker.sv @@
// Checker for the printable character histogram core: predicts results and compares them.
`timescale 1ns / 100ps

module phc_checker
    import phc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [2:0]          s_func,
    input  logic [7:0]          s_data_byte,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [VALUE_W-1:0]  m_value,
    input  logic                m_kind,
    input  logic                m_code_valid,
    output int                  fail_count,
    output int                  pending_words
);

    localparam logic KIND_SESSION = 1'b0;
    localparam logic KIND_TOTAL   = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               kind;
        logic               code_valid;
    } hist_word_t;

    logic [COUNT_WIDTH-1:0] session_hist [CHAR_CLASSES];
    logic [COUNT_WIDTH-1:0] total_hist [CHAR_CLASSES];
    logic [COUNT_WIDTH-1:0] session_chars;
    hist_word_t             count_queue [$];

    function automatic logic in_print_range(logic [7:0] code);
        return code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE;
    endfunction

    task automatic clear_session();
        for (int i = 0; i < CHAR_CLASSES; i++) begin
            session_hist[i] = '0;
        end
        session_chars = '0;
    endtask

    task automatic predict_word(logic [2:0] func, logic [7:0] code);
        hist_word_t w;
        w = '0;
        case (func)
            FUNC_DATA: begin
                if (in_print_range(code)) begin
                    session_hist[code - FIRST_PRINTABLE] += 1'b1;
                    session_chars += 1'b1;
                end
            end
            FUNC_EOS: begin
                w.value      = VALUE_W'(session_chars);
                w.kind       = KIND_SESSION;
                w.code_valid = 1'b0;
                count_queue.push_back(w);
            end
            FUNC_COMMIT: begin
                for (int i = 0; i < CHAR_CLASSES; i++) begin
                    total_hist[i] += session_hist[i];
                end
                clear_session();
            end
            FUNC_ABORT: begin
                clear_session();
            end
            FUNC_READ: begin
                w.kind = KIND_TOTAL;
                if (in_print_range(code)) begin
                    w.value      = VALUE_W'(total_hist[code - FIRST_PRINTABLE]);
                    w.code_valid = 1'b1;
                end
                count_queue.push_back(w);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_word();
        hist_word_t w;
        if (count_queue.size() == 0) begin
            $display("%0t: unexpected result value %h kind %b code_valid %b",
                     $time, m_value, m_kind, m_code_valid);
            fail_count++;
        end else begin
            w = count_queue.pop_front();
            if (m_value !== w.value) begin
                $display("%0t: value mismatch expected %h actual %h", $time, w.value, m_value);
                fail_count++;
            end
            if (m_kind !== w.kind) begin
                $display("%0t: kind mismatch expected %b actual %b", $time, w.kind, m_kind);
                fail_count++;
            end
            if (m_code_valid !== w.code_valid) begin
                $display("%0t: code_valid mismatch expected %b actual %b",
                         $time, w.code_valid, m_code_valid);
                fail_count++;
            end
        end
    endtask

    initial begin
        fail_count    = 0;
        pending_words = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_session();
            for (int i = 0; i < CHAR_CLASSES; i++) begin
                total_hist[i] = '0;
            end
            count_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_word();
            end
            if (s_valid && s_ready) begin
                predict_word(s_func, s_data_byte);
            end
        end
        pending_words = count_queue.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the printable character histogram testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import phc_pkg::*;

    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_WORDS     = 1650;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         DRAIN_CYCLES     = 250;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_func;
    logic [7:0]         s_data_byte;
    logic               m_valid;
    logic               m_ready;
    logic [VALUE_W-1:0] m_value;
    logic               m_kind;
    logic               m_code_valid;
    int                 fail_count;
    int                 pending_words;
    int                 idle_cycles;
    int                 word_count;
    logic               quiet;

    printable_char_histogram_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_kind       (m_kind),
        .m_code_valid (m_code_valid)
    );

    phc_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_kind        (m_kind),
        .m_code_valid  (m_code_valid),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 7) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
    endfunction

    task automatic send_word(logic [2:0] func, logic [7:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_data_byte <= code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        word_count++;
    endtask

    task automatic run_session();
        int n;
        int pick;
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
                send_word(FUNC_DATA, pick_char());
            end else if (pick < 17) begin
                send_word(FUNC_READ, pick_char());
            end else if (pick < 19) begin
                send_word(FUNC_EOS, 8'($urandom_range(0, 255)));
            end else begin
                send_word(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                          8'($urandom_range(0, 255)));
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            send_word(FUNC_EOS, 8'($urandom_range(0, 255)));
            send_word(FUNC_COMMIT, 8'($urandom_range(0, 255)));
        end else if (pick < 17) begin
            send_word(FUNC_EOS, 8'($urandom_range(0, 255)));
            send_word(FUNC_ABORT, 8'($urandom_range(0, 255)));
        end else if (pick < 19) begin
            send_word(FUNC_COMMIT, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 0) begin
            send_word(FUNC_READ, pick_char());
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_func      = FUNC_DATA;
        s_data_byte = '0;
        quiet       = 1'b0;
        word_count  = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_word(FUNC_READ, FIRST_PRINTABLE);
        send_word(FUNC_READ, LAST_PRINTABLE);
        send_word(FUNC_READ, 8'h00);
        send_word(FUNC_READ, 8'hff);
        send_word(FUNC_EOS, 8'h00);
        send_word(FUNC_DATA, FIRST_PRINTABLE);
        send_word(FUNC_DATA, LAST_PRINTABLE);
        send_word(FUNC_DATA, FIRST_PRINTABLE - 8'd1);
        send_word(FUNC_DATA, LAST_PRINTABLE + 8'd1);
        send_word(FUNC_DATA, 8'h00);
        send_word(FUNC_DATA, 8'hff);
        send_word(FUNC_EOS, 8'hff);
        send_word(FUNC_COMMIT, 8'h00);
        send_word(FUNC_READ, FIRST_PRINTABLE);
        send_word(FUNC_READ, LAST_PRINTABLE);
        send_word(FUNC_READ, FIRST_PRINTABLE - 8'd1);
        send_word(FUNC_READ, LAST_PRINTABLE + 8'd1);
        send_word(FUNC_DATA, 8'h41);
        send_word(FUNC_ABORT, 8'h00);
        send_word(FUNC_EOS, 8'h00);
        send_word(FUNC_READ, 8'h41);
        send_word(FUNC_SPARE_FIRST, 8'h41);
        send_word(FUNC_SPARE_MID, 8'hff);
        send_word(FUNC_SPARE_LAST, 8'h20);
        send_word(FUNC_COMMIT, 8'h00);
        send_word(FUNC_EOS, 8'h00);

        while (word_count < RANDOM_WORDS) begin
            quiet = ($urandom_range(0, 3) == 0);
            run_session();
        end
        s_valid <= 1'b0;

        while (pending_words != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/phc_pkg.sv
rtl/printable_char_histogram_core.sv
tb/phc_checker.sv
tb/testbench.sv
